### hdl/csvfs_pkg.sv
`default_nettype none

package csvfs_pkg;

  localparam int unsigned FieldLimitDef = 256;

  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharNl    = 8'h0A;

  typedef enum logic [2:0] {
    QsUnquoted = 3'b001,
    QsQuoted   = 3'b010,
    QsQquote   = 3'b100
  } qstate_e;

  // One classified input word: up to two results.
  typedef struct packed {
    logic       has0;
    logic [7:0] data0;
    logic       bvalid0;
    logic [7:0] fidx0;
    logic       fend0;
    logic       rend0;
    logic       has1;
    logic [7:0] fidx1;
  } cmd_t;

endpackage

`default_nettype wire

### hdl/csv_field_splitter_core.sv
// channel | dir | tdata                     | tuser                       | tlast
// s       | in  | [7:0] in_byte             | -                           | end_of_input
// m       | out | [7:0] data_byte,          | [0] byte_valid,             | run_last
//         |     | [15:8] field_index        | [1] field_end, [2] row_end  |
//
// One input word per cycle while the queue is not full; a word yields zero to two
// output words, two only on an end-of-input word that is not a newline.
// A first output word is valid once its input is written to the queue and then
// loaded into the output register.
// Reset clears the quote state, field index, queue and output valid.
// Input stalls only while the queue is full; output stalls hold the output register.
`default_nettype none

module csv_field_splitter_core #(
  parameter int unsigned FieldLimit = csvfs_pkg::FieldLimitDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [7:0]  s_tdata_i,   // [7:0] in_byte
  input  wire logic        s_tlast_i,
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [15:0]      m_tdata_o,   // [7:0] data_byte, [15:8] field_index
  output logic [2:0]       m_tuser_o,   // [0] byte_valid, [1] field_end, [2] row_end
  output logic             m_tlast_o
);
  import csvfs_pkg::*;

  cmd_t push_data, head;
  logic push, pop, full, empty;

  csvfs_front #(
    .FieldLimit(FieldLimit)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .s_tlast_i (s_tlast_i),
    .q_full_i  (full),
    .q_push_o  (push),
    .q_data_o  (push_data)
  );

  csvfs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  csvfs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (empty),
    .q_head_i  (head),
    .q_pop_o   (pop),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .m_tuser_o (m_tuser_o),
    .m_tlast_o (m_tlast_o)
  );

endmodule

`default_nettype wire

### hdl/csvfs_front.sv
`default_nettype none

module csvfs_front #(
  parameter int unsigned FieldLimit = csvfs_pkg::FieldLimitDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_tvalid_i,
  output logic               s_tready_o,
  input  wire logic [7:0]    s_tdata_i,
  input  wire logic          s_tlast_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output csvfs_pkg::cmd_t    q_data_o
);
  import csvfs_pkg::*;

  localparam logic [7:0] MaxIdx = (FieldLimit - 1 > 255) ? 8'd255 : 8'(FieldLimit - 1);

  qstate_e    state_q, state_d;
  logic [7:0] field_q, field_d;
  logic [7:0] field_inc;
  logic       accept;
  cmd_t       cmd;

  assign s_tready_o = !q_full_i;
  assign accept     = s_tvalid_i && s_tready_o;
  assign field_inc  = (field_q < MaxIdx) ? field_q + 8'd1 : field_q;

  always_comb begin
    cmd         = '0;
    cmd.fidx0   = field_q;
    state_d     = state_q;
    field_d     = field_q;
    if (s_tdata_i == CharNl) begin
      cmd.has0  = 1'b1;
      cmd.fend0 = 1'b1;
      cmd.rend0 = 1'b1;
      state_d   = QsUnquoted;
      field_d   = 8'd0;
    end else begin
      case (state_q)
        QsQuoted: begin
          if (s_tdata_i == CharQuote) begin
            state_d = QsQquote;
          end else begin
            cmd.has0    = 1'b1;
            cmd.bvalid0 = 1'b1;
            cmd.data0   = s_tdata_i;
          end
        end
        QsQquote: begin
          if (s_tdata_i == CharComma) begin
            cmd.has0  = 1'b1;
            cmd.fend0 = 1'b1;
            field_d   = field_inc;
            state_d   = QsUnquoted;
          end else if (s_tdata_i == CharQuote) begin
            cmd.has0    = 1'b1;
            cmd.bvalid0 = 1'b1;
            cmd.data0   = CharQuote;
            state_d     = QsQuoted;
          end else begin
            state_d = QsUnquoted;
          end
        end
        default: begin
          if (s_tdata_i == CharComma) begin
            cmd.has0  = 1'b1;
            cmd.fend0 = 1'b1;
            field_d   = field_inc;
            state_d   = QsUnquoted;
          end else if (s_tdata_i == CharQuote) begin
            state_d = QsQuoted;
          end else begin
            cmd.has0    = 1'b1;
            cmd.bvalid0 = 1'b1;
            cmd.data0   = s_tdata_i;
            state_d     = QsUnquoted;
          end
        end
      endcase
      if (s_tlast_i) begin
        cmd.has1  = 1'b1;
        cmd.fidx1 = field_d;
        state_d   = QsUnquoted;
        field_d   = 8'd0;
      end
    end
  end

  assign q_push_o = accept && (cmd.has0 || cmd.has1);
  assign q_data_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= QsUnquoted;
      field_q <= 8'd0;
    end else if (accept) begin
      state_q <= state_d;
      field_q <= field_d;
    end
  end

endmodule

`default_nettype wire

### hdl/csvfs_queue.sv
`default_nettype none

module csvfs_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire csvfs_pkg::cmd_t  push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output csvfs_pkg::cmd_t       head_o
);
  import csvfs_pkg::*;

  cmd_t       entries_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### hdl/csvfs_back.sv
`default_nettype none

module csvfs_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_empty_i,
  input  wire csvfs_pkg::cmd_t  q_head_i,
  output logic                  q_pop_o,
  output logic                  m_tvalid_o,
  input  wire logic             m_tready_i,
  output logic [15:0]           m_tdata_o,
  output logic [2:0]            m_tuser_o,
  output logic                  m_tlast_o
);
  import csvfs_pkg::*;

  logic        phase_q, phase_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] tdata_q, tdata_d;
  logic [2:0]  tuser_q, tuser_d;
  logic        tlast_q, tlast_d;
  logic        load, second;

  assign load   = !q_empty_i && (!out_valid_q || m_tready_i);
  assign second = phase_q || !q_head_i.has0;

  always_comb begin
    phase_d = phase_q;
    q_pop_o = 1'b0;
    if (second) begin
      tdata_d = {q_head_i.fidx1, 8'd0};
      tuser_d = 3'b110;
      tlast_d = 1'b1;
    end else begin
      tdata_d = {q_head_i.fidx0, q_head_i.data0};
      tuser_d = {q_head_i.rend0, q_head_i.fend0, q_head_i.bvalid0};
      tlast_d = !q_head_i.has1;
    end
    if (load) begin
      if (second || !q_head_i.has1) begin
        q_pop_o = 1'b1;
        phase_d = 1'b0;
      end else begin
        phase_d = 1'b1;
      end
    end
    out_valid_d = load ? 1'b1 : (m_tready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
      tlast_q <= tlast_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = tdata_q;
  assign m_tuser_o  = tuser_q;
  assign m_tlast_o  = tlast_q;

endmodule

`default_nettype wire

### hdl/csvfs_checker.sv
`default_nettype none

module csvfs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_tvalid_o,
  input wire logic        m_tready_i,
  input wire logic [15:0] m_tdata_o,
  input wire logic [2:0]  m_tuser_o,
  input wire logic        m_tlast_o
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o)
    else $error("output valid dropped under stall");

  a_row_end_is_field_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[2] |-> m_tuser_o[1])
    else $error("row end without field end");

  a_byte_not_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[0] |-> !m_tuser_o[1])
    else $error("content byte carries field end");

  a_marker_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tuser_o[0] |-> m_tdata_o[7:0] == 8'd0)
    else $error("marker word with nonzero data");

  a_row_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[2] |-> m_tlast_o)
    else $error("row end not last word of its input");

endmodule

bind csv_field_splitter_core csvfs_checker u_csvfs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .m_tvalid_o(m_tvalid_o),
  .m_tready_i(m_tready_i),
  .m_tdata_o (m_tdata_o),
  .m_tuser_o (m_tuser_o),
  .m_tlast_o (m_tlast_o)
);

`default_nettype wire

### tb/csv_field_splitter_core_test.sv
`default_nettype none

module csv_field_splitter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import csvfs_pkg::*;

  localparam int unsigned MaxIdx = (FieldLimitDef - 1 > 255) ? 255 : FieldLimitDef - 1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic [7:0] field_index;
    logic       field_end;
    logic       row_end;
    logic       run_last;
  } split_word_t;

  class csv_scoreboard;
    qstate_e     qs;
    logic [7:0]  fld;
    split_word_t split_q[$];
    int          errors;
    int          rows_seen;
    int          widest;

    function new();
      clear_row();
      errors    = 0;
      rows_seen = 0;
      widest    = 0;
    endfunction

    function void clear_row();
      qs  = QsUnquoted;
      fld = 8'd0;
    endfunction

    function void emit(logic [7:0] d, logic v, logic fe, logic re);
      split_word_t w;
      w.data_byte   = d;
      w.byte_valid  = v;
      w.field_index = fld;
      w.field_end   = fe;
      w.row_end     = re;
      w.run_last    = 1'b0;
      split_q = {split_q, w};
    endfunction

    function void next_field();
      if (fld < MaxIdx) fld++;
    endfunction

    function int pending();
      return split_q.size();
    endfunction

    // Work out what one accepted input word produces.
    function void note_word(logic [7:0] b, logic eoi);
      int n0;
      n0 = split_q.size();
      if (b == CharNl) begin
        emit(8'd0, 1'b0, 1'b1, 1'b1);
        clear_row();
      end else begin
        case (qs)
          QsQuoted: begin
            if (b == CharQuote) qs = QsQquote;
            else emit(b, 1'b1, 1'b0, 1'b0);
          end
          QsQquote: begin
            if (b == CharComma) begin
              emit(8'd0, 1'b0, 1'b1, 1'b0);
              next_field();
              qs = QsUnquoted;
            end else if (b == CharQuote) begin
              emit(CharQuote, 1'b1, 1'b0, 1'b0);
              qs = QsQuoted;
            end else begin
              qs = QsUnquoted;
            end
          end
          default: begin
            if (b == CharComma) begin
              emit(8'd0, 1'b0, 1'b1, 1'b0);
              next_field();
            end else if (b == CharQuote) begin
              qs = QsQuoted;
            end else begin
              emit(b, 1'b1, 1'b0, 1'b0);
            end
          end
        endcase
        if (eoi) begin
          emit(8'd0, 1'b0, 1'b1, 1'b1);
          clear_row();
        end
      end
      if (split_q.size() > n0) split_q[split_q.size() - 1].run_last = 1'b1;
    endfunction

    function void cmp(string name, int e, int a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
      end
    endfunction

    function void check_word(split_word_t got);
      split_word_t exp;
      if (split_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output word, expected none, actual %p", $time, got);
        return;
      end
      exp = split_q.pop_front();
      cmp("data_byte", exp.data_byte, got.data_byte);
      cmp("byte_valid", exp.byte_valid, got.byte_valid);
      cmp("field_index", exp.field_index, got.field_index);
      cmp("field_end", exp.field_end, got.field_end);
      cmp("row_end", exp.row_end, got.row_end);
      cmp("run_last", exp.run_last, got.run_last);
      if (got.row_end) rows_seen++;
      if (int'(got.field_index) > widest) widest = int'(got.field_index);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic [7:0]  s_tdata_i = 8'd0;
  logic        s_tlast_i = 1'b0;
  logic        m_tready_i = 1'b0;
  logic        s_tready_o;
  logic        m_tvalid_o;
  logic [15:0] m_tdata_o;
  logic [2:0]  m_tuser_o;
  logic        m_tlast_o;

  csv_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;

  csv_field_splitter_core #(
    .FieldLimit(FieldLimitDef)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) begin
        sb.check_word({m_tdata_o[7:0], m_tuser_o[0], m_tdata_o[15:8],
                       m_tuser_o[1], m_tuser_o[2], m_tlast_o});
      end
      m_tready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic put_word(input logic [7:0] b, input logic eoi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= b;
    s_tlast_i  <= eoi;
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_word(b, eoi);
    words_sent++;
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CharComma || b == CharQuote || b == CharNl);
    return b;
  endfunction

  task automatic put_directed();
    logic [8:0] dir_words [26] = '{
      {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, CharComma}, {1'b0, CharQuote},
      {1'b0, CharComma}, {1'b0, CharNl},
      {1'b0, CharQuote}, {1'b0, CharQuote}, {1'b0, CharQuote}, {1'b0, 8'h78},
      {1'b0, CharQuote}, {1'b0, 8'h79}, {1'b0, 8'h0D}, {1'b0, CharComma},
      {1'b0, CharQuote}, {1'b0, CharQuote}, {1'b0, CharComma}, {1'b1, CharNl},
      {1'b1, 8'h7A}, {1'b1, CharComma}, {1'b1, CharQuote},
      {1'b0, CharQuote}, {1'b1, 8'h61},
      {1'b0, CharQuote}, {1'b0, CharQuote}, {1'b1, CharQuote}
    };
    foreach (dir_words[i]) put_word(dir_words[i][7:0], dir_words[i][8]);
  endtask

  task automatic put_row(input int nf);
    logic [7:0] row_q[$];
    int len;
    int kind;
    int ending;
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 8);
      repeat (len) row_q = {row_q, 8'($urandom_range(0, 255))};
      ending = ($urandom_range(0, 5) == 0) ? 0 : 2;
    end else begin
      for (int f = 0; f < nf; f++) begin
        if (f > 0) row_q = {row_q, CharComma};
        kind = $urandom_range(0, 9);
        len  = $urandom_range(0, 5);
        if (kind < 6) begin
          repeat (len) row_q = {row_q, plain_byte()};
        end else begin
          row_q = {row_q, CharQuote};
          repeat (len) begin
            case ($urandom_range(0, 7))
              0: begin
                row_q = {row_q, CharQuote, CharQuote};
              end
              1: row_q = {row_q, CharComma};
              default: row_q = {row_q, plain_byte()};
            endcase
          end
          row_q = {row_q, CharQuote};
          if (kind == 9) row_q = {row_q, plain_byte()};
        end
      end
      ending = $urandom_range(0, 7);
      if (ending == 0 && row_q.size() == 0) row_q = {row_q, plain_byte()};
      if (ending != 0) row_q = {row_q, CharNl};
    end
    foreach (row_q[i]) put_word(row_q[i], (i == row_q.size() - 1) && ending < 2);
  endtask

  task automatic put_wide_row(input int nf);
    for (int f = 1; f < nf; f++) put_word(CharComma, 1'b0);
    put_word(plain_byte(), 1'b0);
    put_word(CharNl, 1'b0);
  endtask

  task automatic run_phase(input int idle, input int stall, input int budget);
    int start;
    start = words_sent;
    send_idle_pct = idle;
    stall_pct = stall;
    while (words_sent - start < budget) put_row($urandom_range(1, 6));
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    put_directed();
    drain();
    run_phase(0, 0, 100);
    run_phase(58, 0, 100);
    drain();
    run_phase(0, 58, 100);
    send_idle_pct = 16;
    stall_pct = 16;
    put_wide_row($urandom_range(258, 290));
    run_phase(16, 16, 100);
    run_phase(0, 0, 100);

    s_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected words never arrived", $time, sb.pending());
    end

    $display("Covered %0d input words and %0d rows across idle and stall mixes,",
             words_sent, sb.rows_seen);
    $display("with quoted fields, doubled quotes, end-of-input and field index up to %0d.",
             sb.widest);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### csv_field_splitter_core.f
hdl/csvfs_pkg.sv
hdl/csvfs_front.sv
hdl/csvfs_queue.sv
hdl/csvfs_back.sv
hdl/csv_field_splitter_core.sv
hdl/csvfs_checker.sv
tb/csv_field_splitter_core_test.sv
